@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHK_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("check failed");
`define CHK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("check failed");
`else
`define CHK_IMPL(lbl, ante, cons)
`define CHK_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/llet_pkg.sv @@
package llet_pkg;
	typedef struct packed {
		logic [31:0] key;
		logic [31:0] atime;
		logic [31:0] cnt;
		logic [47:0] usage;
	} ent_t;

	localparam int ENT_W = $bits(ent_t);

	localparam logic [2:0] MODE_ACCESS = 3'd0;
	localparam logic [2:0] MODE_UPDATE = 3'd1;
	localparam logic [2:0] MODE_REMOVE = 3'd2;
	localparam logic [2:0] MODE_SELECT = 3'd3;
	localparam logic [2:0] MODE_EVICT  = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOTFOUND = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;

	localparam logic [1:0] POL_LRU = 2'd0;
	localparam logic [1:0] POL_LFU = 2'd1;

	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_LIMIT  = 1'b1;
endpackage

@@ sv/llet_ram.sv @@
module llet_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

@@ sv/lru_lfu_eviction_tracker.sv @@
// Eviction tracker: a table of up to ENTRIES keyed entries in insertion order, held in one
// single-port-read RAM with registered read. Every access, update and remove scans the table
// one entry per cycle to find the key; select and evict scan all entries to pick the victim
// (LRU, LFU or oldest). Removing an entry shifts the entries behind it down one per cycle.
// An access or update is taken, looked up, applied and loaded into the output register; a
// remove adds the shift after applying; a select scans for the victim before loading the
// output. An evict repeats victim scan, shift and output load for each evicted key while the
// total stays over the limit and entries remain. Loading the output register waits while it
// still holds a result that is not taken. A new item is taken while the previous result still
// waits in the output register.
module lru_lfu_eviction_tracker #(
	parameter int ENTRIES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [111:0] s_tdata,   // key[31:0], now[63:32], delta[111:64]
	input  logic [2:0]   s_tuser,   // mode[2:0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [87:0]  m_tdata,   // victim_key[31:0], total_memory[79:32], over_limit[80]
	output logic [2:0]   m_tuser,   // status[1:0], victim_valid[2]
	output logic         m_tlast,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [47:0]  cfg_data
);
	localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [CW-1:0] CAP = CW'(ENTRIES);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_APPLY = 3'd2;
	localparam logic [2:0] S_VSCAN = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0]  state_q;
	logic [2:0]  mode_q;
	logic [31:0] key_q, now_q;
	logic [47:0] delta_q;
	logic [1:0]  policy_q;
	logic [47:0] limit_q, total_q;
	logic [CW-1:0] count_q, ptr_q, idx_q, rix_s1;
	logic        vld_s1, found_q;
	llet_pkg::ent_t rec_q, rdata, wdata;
	logic [1:0]  status_q;
	logic        vv_q;
	logic        we;
	logic [AW-1:0] waddr;
	logic        issue, scan_done, emit_go, last_c, better;

	logic        oval_q, olast_q, oover_q, ovv_q;
	logic [1:0]  ost_q;
	logic [31:0] okey_q;
	logic [47:0] ototal_q;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign issue     = (ptr_q < count_q);
	assign scan_done = !vld_s1 && !issue;
	assign emit_go   = !oval_q || m_tready;
	assign last_c    = !((mode_q == llet_pkg::MODE_EVICT) && vv_q
		&& (total_q > limit_q) && (count_q != '0));

	always_comb begin
		better = 1'b0;
		if (rix_s1 == '0) begin
			better = 1'b1;
		end else if (policy_q == llet_pkg::POL_LRU) begin
			better = rdata.atime < rec_q.atime;
		end else if (policy_q == llet_pkg::POL_LFU) begin
			better = rdata.cnt < rec_q.cnt;
		end
	end

	llet_ram #(.WIDTH(llet_pkg::ENT_W), .DEPTH(ENTRIES)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	// write port: entry refresh, append, or one step of the shift-down
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rec_q;
		if (state_q == S_APPLY) begin
			if (mode_q == llet_pkg::MODE_ACCESS || mode_q == llet_pkg::MODE_UPDATE) begin
				if (found_q) begin
					we = 1'b1;
					if (mode_q == llet_pkg::MODE_ACCESS) begin
						wdata.atime = now_q;
						if (rec_q.cnt != 32'hFFFF_FFFF) begin
							wdata.cnt = rec_q.cnt + 32'd1;
						end
					end else begin
						wdata.usage = rec_q.usage + delta_q;
					end
				end else if (count_q != CAP) begin
					we          = 1'b1;
					waddr       = count_q[AW-1:0];
					wdata.key   = key_q;
					wdata.atime = now_q;
					wdata.cnt   = 32'd1;
					wdata.usage = (mode_q == llet_pkg::MODE_UPDATE) ? delta_q : 48'd0;
				end
			end
		end else if (state_q == S_SHIFT && vld_s1) begin
			we    = 1'b1;
			waddr = AW'(rix_s1 - CW'(1));
			wdata = rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			policy_q <= '0;
			limit_q  <= '0;
			total_q  <= '0;
			count_q  <= '0;
			ptr_q    <= '0;
			vld_s1   <= 1'b0;
			oval_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				if (cfg_index[0] == llet_pkg::REG_POLICY) begin
					policy_q <= cfg_data[1:0];
				end else begin
					limit_q <= cfg_data;
				end
			end
			if (state_q == S_EMIT && emit_go) begin
				oval_q <= 1'b1;
			end else if (m_tready) begin
				oval_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						mode_q   <= s_tuser;
						key_q    <= s_tdata[31:0];
						now_q    <= s_tdata[63:32];
						delta_q  <= s_tdata[111:64];
						status_q <= llet_pkg::ST_OK;
						vv_q     <= 1'b0;
						found_q  <= 1'b0;
						ptr_q    <= '0;
						vld_s1   <= 1'b0;
						unique case (s_tuser) inside
							llet_pkg::MODE_ACCESS, llet_pkg::MODE_UPDATE,
							llet_pkg::MODE_REMOVE: state_q <= S_LOOK;
							llet_pkg::MODE_SELECT: begin
								if (count_q == '0) begin
									status_q <= llet_pkg::ST_NOTFOUND;
									state_q  <= S_EMIT;
								end else begin
									state_q <= S_VSCAN;
								end
							end
							llet_pkg::MODE_EVICT: begin
								if (total_q > limit_q && count_q != '0) begin
									state_q <= S_VSCAN;
								end else begin
									status_q <= (total_q > limit_q) ? llet_pkg::ST_NOTFOUND
										: llet_pkg::ST_OK;
									state_q <= S_EMIT;
								end
							end
							default: state_q <= S_EMIT;
						endcase
					end
				end
				S_LOOK: begin
					if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					vld_s1 <= issue;
					rix_s1 <= ptr_q;
					if (vld_s1 && rdata.key == key_q) begin
						rec_q   <= rdata;
						idx_q   <= rix_s1;
						found_q <= 1'b1;
						state_q <= S_APPLY;
					end else if (scan_done) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q <= S_EMIT;
					if (mode_q == llet_pkg::MODE_REMOVE) begin
						if (found_q) begin
							total_q <= total_q - rec_q.usage;
							ptr_q   <= idx_q + CW'(1);
							vld_s1  <= 1'b0;
							state_q <= S_SHIFT;
						end else begin
							status_q <= llet_pkg::ST_NOTFOUND;
						end
					end else if (found_q) begin
						if (mode_q == llet_pkg::MODE_UPDATE) begin
							total_q <= total_q + delta_q;
						end
					end else if (count_q == CAP) begin
						status_q <= llet_pkg::ST_FULL;
					end else begin
						count_q <= count_q + CW'(1);
						if (mode_q == llet_pkg::MODE_UPDATE) begin
							total_q <= total_q + delta_q;
						end
					end
				end
				S_VSCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					vld_s1 <= issue;
					rix_s1 <= ptr_q;
					if (vld_s1 && better) begin
						rec_q <= rdata;
						idx_q <= rix_s1;
					end else if (scan_done) begin
						vv_q <= 1'b1;
						if (mode_q == llet_pkg::MODE_EVICT) begin
							total_q <= total_q - rec_q.usage;
							ptr_q   <= idx_q + CW'(1);
							state_q <= S_SHIFT;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_SHIFT: begin
					if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					vld_s1 <= issue;
					rix_s1 <= ptr_q;
					if (scan_done) begin
						count_q <= count_q - CW'(1);
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						ost_q    <= status_q;
						ovv_q    <= vv_q;
						okey_q   <= vv_q ? rec_q.key : 32'd0;
						ototal_q <= total_q;
						oover_q  <= total_q > limit_q;
						olast_q  <= last_c;
						if (last_c) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q   <= '0;
							vld_s1  <= 1'b0;
							state_q <= S_VSCAN;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = oval_q;
	assign m_tdata  = {7'd0, oover_q, ototal_q, okey_q};
	assign m_tuser  = {ovv_q, ost_q};
	assign m_tlast  = olast_q;

	`include "assert_macros.svh"
	`CHK_IMPL(a_count_cap, 1'b1, count_q <= CAP)
	`CHK_IMPL(a_no_write_idle, state_q == S_IDLE, !we)
	`CHK_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready)
	`CHK_IMPL(a_out_from_emit, $rose(m_tvalid), $past(state_q) == S_EMIT)
endmodule

@@ test/lru_lfu_eviction_checker.sv @@
`timescale 1ns / 1ps

module lru_lfu_eviction_checker #(
	parameter int ENTRIES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [111:0] s_tdata,
	input  logic [2:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [87:0]  m_tdata,
	input  logic [2:0]   m_tuser,
	input  logic         m_tlast,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [47:0]  cfg_data,
	output int           errors,
	output int           pending,
	output int           results_seen
);
	typedef struct packed {
		logic [1:0]  status;
		logic        victim_valid;
		logic [31:0] victim_key;
		logic [47:0] total;
		logic        over;
		logic        last;
	} verdict_t;

	verdict_t    verdict_q[$];
	logic [31:0] tbl_key[ENTRIES];
	logic [31:0] tbl_time[ENTRIES];
	logic [31:0] tbl_count[ENTRIES];
	logic [47:0] tbl_usage[ENTRIES];
	int          fill;
	logic [47:0] byte_total;
	logic [1:0]  cur_policy;
	logic [47:0] cur_limit;

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		errors++;
	endtask

	task automatic push_verdict(input logic [1:0] st, input logic vv, input logic [31:0] vk,
			input logic lst);
		verdict_t v;
		v.status       = st;
		v.victim_valid = vv;
		v.victim_key   = vk;
		v.total        = byte_total;
		v.over         = byte_total > cur_limit;
		v.last         = lst;
		verdict_q.push_back(v);
	endtask

	function automatic int find_key(input logic [31:0] k);
		for (int i = 0; i < fill; i++)
			if (tbl_key[i] == k)
				return i;
		return -1;
	endfunction

	// strict compare keeps ties on the earliest inserted entry
	function automatic int pick_victim();
		int v;
		v = 0;
		for (int i = 1; i < fill; i++) begin
			if (cur_policy == llet_pkg::POL_LRU && tbl_time[i] < tbl_time[v])
				v = i;
			else if (cur_policy == llet_pkg::POL_LFU && tbl_count[i] < tbl_count[v])
				v = i;
		end
		return v;
	endfunction

	task automatic add_entry(input logic [31:0] k, input logic [31:0] t, input logic [47:0] u);
		tbl_key[fill]   = k;
		tbl_time[fill]  = t;
		tbl_count[fill] = 32'd1;
		tbl_usage[fill] = u;
		fill++;
	endtask

	task automatic drop_entry(input int idx);
		byte_total = byte_total - tbl_usage[idx];
		for (int i = idx; i + 1 < fill; i++) begin
			tbl_key[i]   = tbl_key[i + 1];
			tbl_time[i]  = tbl_time[i + 1];
			tbl_count[i] = tbl_count[i + 1];
			tbl_usage[i] = tbl_usage[i + 1];
		end
		fill--;
	endtask

	task automatic apply_item(input logic [2:0] mode, input logic [31:0] k, input logic [31:0] t,
			input logic [47:0] d);
		int       idx;
		int       n;
		int       v;
		logic [31:0] vk;
		verdict_t tail;
		idx = find_key(k);
		case (mode)
			llet_pkg::MODE_ACCESS: begin
				if (idx >= 0) begin
					tbl_time[idx] = t;
					if (tbl_count[idx] != 32'hFFFF_FFFF)
						tbl_count[idx]++;
					push_verdict(llet_pkg::ST_OK, 1'b0, 32'd0, 1'b1);
				end else if (fill < ENTRIES) begin
					add_entry(k, t, 48'd0);
					push_verdict(llet_pkg::ST_OK, 1'b0, 32'd0, 1'b1);
				end else begin
					push_verdict(llet_pkg::ST_FULL, 1'b0, 32'd0, 1'b1);
				end
			end
			llet_pkg::MODE_UPDATE: begin
				if (idx < 0 && fill >= ENTRIES) begin
					push_verdict(llet_pkg::ST_FULL, 1'b0, 32'd0, 1'b1);
				end else begin
					if (idx >= 0)
						tbl_usage[idx] = tbl_usage[idx] + d;
					else
						add_entry(k, t, d);
					byte_total = byte_total + d;
					push_verdict(llet_pkg::ST_OK, 1'b0, 32'd0, 1'b1);
				end
			end
			llet_pkg::MODE_REMOVE: begin
				if (idx < 0) begin
					push_verdict(llet_pkg::ST_NOTFOUND, 1'b0, 32'd0, 1'b1);
				end else begin
					drop_entry(idx);
					push_verdict(llet_pkg::ST_OK, 1'b0, 32'd0, 1'b1);
				end
			end
			llet_pkg::MODE_SELECT: begin
				if (fill == 0)
					push_verdict(llet_pkg::ST_NOTFOUND, 1'b0, 32'd0, 1'b1);
				else
					push_verdict(llet_pkg::ST_OK, 1'b1, tbl_key[pick_victim()], 1'b1);
			end
			llet_pkg::MODE_EVICT: begin
				n = 0;
				while (byte_total > cur_limit && fill > 0 && n < ENTRIES) begin
					v  = pick_victim();
					vk = tbl_key[v];
					drop_entry(v);
					push_verdict(llet_pkg::ST_OK, 1'b1, vk, 1'b0);
					n++;
				end
				if (n == 0) begin
					push_verdict((byte_total > cur_limit) ? llet_pkg::ST_NOTFOUND
						: llet_pkg::ST_OK, 1'b0, 32'd0, 1'b1);
				end else begin
					tail      = verdict_q.pop_back();
					tail.last = 1'b1;
					verdict_q.push_back(tail);
				end
			end
			default: push_verdict(llet_pkg::ST_OK, 1'b0, 32'd0, 1'b1);
		endcase
	endtask

	task automatic check_result();
		verdict_t want;
		if (verdict_q.size() == 0) begin
			$display("%0t: result transfer with nothing expected", $time);
			errors++;
		end else begin
			want = verdict_q.pop_front();
			if (m_tuser[1:0] != want.status)
				report("status", 64'(m_tuser[1:0]), 64'(want.status));
			if (m_tuser[2] != want.victim_valid)
				report("victim_valid", 64'(m_tuser[2]), 64'(want.victim_valid));
			if (m_tdata[31:0] != want.victim_key)
				report("victim_key", 64'(m_tdata[31:0]), 64'(want.victim_key));
			if (m_tdata[79:32] != want.total)
				report("total_memory", 64'(m_tdata[79:32]), 64'(want.total));
			if (m_tdata[80] != want.over)
				report("over_limit", 64'(m_tdata[80]), 64'(want.over));
			if (m_tlast != want.last)
				report("last", 64'(m_tlast), 64'(want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_q.delete();
			fill         = 0;
			byte_total   = 48'd0;
			cur_policy   = llet_pkg::POL_LRU;
			cur_limit    = 48'd0;
			errors       = 0;
			pending      = 0;
			results_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
				results_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == llet_pkg::REG_POLICY)
					cur_policy = cfg_data[1:0];
				else
					cur_limit = cfg_data;
			end
			if (s_tvalid && s_tready)
				apply_item(s_tuser, s_tdata[31:0], s_tdata[63:32], s_tdata[111:64]);
			pending = verdict_q.size();
		end
	end
endmodule

@@ test/tb_lru_lfu_eviction_tracker.sv @@
`timescale 1ns / 1ps

module tb_lru_lfu_eviction_tracker;
	localparam int ENTRIES      = 64;
	localparam int STALL_LIMIT  = 40000;
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;
	localparam int HOLD_CYCLES  = 400;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [111:0] s_tdata;   // key[31:0], now[63:32], delta[111:64]
	logic [2:0]   s_tuser;   // mode[2:0]
	logic         m_tvalid;
	logic         m_tready;
	logic [87:0]  m_tdata;   // victim_key[31:0], total_memory[79:32], over_limit[80]
	logic [2:0]   m_tuser;   // status[1:0], victim_valid[2]
	logic         m_tlast;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [0:0]   cfg_index;
	logic [47:0]  cfg_data;

	int   errors;
	int   pending;
	int   results_seen;
	int   items_sent;
	int   stall_count = 0;
	logic quiet;
	logic hold_req;

	lru_lfu_eviction_tracker #(.ENTRIES(ENTRIES)) dut (.*);

	lru_lfu_eviction_checker #(.ENTRIES(ENTRIES)) checker_i (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// watchdog: count cycles in which no transfer happens on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
	end

	initial begin
		wait (stall_count >= STALL_LIMIT);
		$display("timeout after %0d idle cycles", STALL_LIMIT);
		$display("lru_lfu_eviction_tracker test failed");
		$finish;
	end

	// result side: random back-pressure plus one long hold on request
	initial begin
		logic held;
		held     = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !held) begin
				held     = 1'b1;
				m_tready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 11) - 1) @(negedge clk);
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	// called at a falling edge, returns at a falling edge with valid still high
	task automatic send_item(input logic [2:0] mode, input logic [31:0] k, input logic [31:0] t,
			input logic [47:0] d);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = mode;
		s_tdata  = {d, t, k};
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic settle();
		s_tvalid = 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [47:0] val);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [47:0] rand_delta();
		case ($urandom_range(0, 3))
			0:       return 48'({$urandom, $urandom});
			1:       return 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3));
			default: return 48'($urandom_range(0, 2000));
		endcase
	endfunction

	task automatic send_random();
		logic [2:0]  mode;
		logic [31:0] k;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			mode = llet_pkg::MODE_ACCESS;
		else if (pick < 60)
			mode = llet_pkg::MODE_UPDATE;
		else if (pick < 72)
			mode = llet_pkg::MODE_REMOVE;
		else if (pick < 84)
			mode = llet_pkg::MODE_SELECT;
		else if (pick < 96)
			mode = llet_pkg::MODE_EVICT;
		else
			mode = llet_pkg::MODE_EVICT + 3'($urandom_range(1, 3));
		// a small key pool makes hits likely; odd wide keys hit the upper bits
		k = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 11));
		send_item(mode, k, $urandom, rand_delta());
	endtask

	initial begin
		logic [47:0] limits[3];
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = llet_pkg::MODE_ACCESS;
		cfg_valid = 1'b0;
		cfg_index = llet_pkg::REG_POLICY;
		cfg_data  = '0;
		quiet     = 1'b0;
		hold_req  = 1'b0;
		items_sent  = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty table, unused modes, wrap of usage and total, evict all
		send_item(llet_pkg::MODE_SELECT, 32'd1, 32'd0, 48'd0);
		send_item(llet_pkg::MODE_REMOVE, 32'd5, 32'd0, 48'd0);
		send_item(llet_pkg::MODE_EVICT, 32'd0, 32'd0, 48'd0);
		send_item(llet_pkg::MODE_EVICT + 3'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			48'hFFFF_FFFF_FFFF);
		send_item(llet_pkg::MODE_EVICT + 3'd2, 32'd0, 32'd0, 48'd0);
		send_item(llet_pkg::MODE_EVICT + 3'd3, 32'd0, 32'd0, 48'd0);
		send_item(llet_pkg::MODE_ACCESS, 32'd0, 32'd0, 48'd0);
		send_item(llet_pkg::MODE_ACCESS, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd0);
		send_item(llet_pkg::MODE_ACCESS, 32'd0, 32'd7, 48'd0);
		send_item(llet_pkg::MODE_UPDATE, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF);
		send_item(llet_pkg::MODE_UPDATE, 32'd0, 32'd0, 48'd2);
		send_item(llet_pkg::MODE_UPDATE, 32'd9, 32'd3, 48'd3);
		send_item(llet_pkg::MODE_SELECT, 32'd0, 32'd0, 48'd0);
		send_item(llet_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'd0, 48'd0);
		send_item(llet_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'd0, 48'd0);
		send_item(llet_pkg::MODE_EVICT, 32'd0, 32'd0, 48'd0);
		send_item(llet_pkg::MODE_EVICT, 32'd0, 32'd0, 48'd0);
		settle();

		// fill the table, then hit it with unknown keys, then evict against a zero limit
		write_reg(llet_pkg::REG_LIMIT, 48'hFFFF_FFFF_FFFF);
		for (int i = 0; i < ENTRIES; i++)
			send_item(i[0] ? llet_pkg::MODE_UPDATE : llet_pkg::MODE_ACCESS, 32'(i * 3 + 100),
				$urandom, 48'($urandom_range(1, 500)));
		send_item(llet_pkg::MODE_ACCESS, 32'd7777, 32'd1, 48'd0);
		send_item(llet_pkg::MODE_UPDATE, 32'd7778, 32'd1, 48'd10);
		send_item(llet_pkg::MODE_ACCESS, 32'd100, 32'd2, 48'd0);
		settle();
		write_reg(llet_pkg::REG_LIMIT, 48'd0);
		send_item(llet_pkg::MODE_EVICT, 32'd0, 32'd0, 48'd0);
		settle();

		limits[0] = 48'hFFFF_FFFF_FFFF;
		limits[1] = 48'd0;
		for (int p = 0; p < 4; p++) begin
			limits[2] = 48'($urandom_range(0, 5000));
			for (int l = 0; l < 3; l++) begin
				write_reg(llet_pkg::REG_POLICY, 48'(p));
				write_reg(llet_pkg::REG_LIMIT, limits[l]);
				quiet = (p == 3 && l == 2);
				if (p == 1 && l == 2)
					hold_req = 1'b1;
				repeat (10) send_random();
				settle();
			end
		end

		$display("sent %0d items and checked %0d results", items_sent, results_seen);
		$display("covered all modes, four policies, extreme limits and a full table");
		if (errors == 0)
			$display("lru_lfu_eviction_tracker test passed");
		else
			$display("lru_lfu_eviction_tracker test failed");
		$finish;
	end
endmodule

@@ sim.f @@
+incdir+sv
sv/llet_pkg.sv
sv/llet_ram.sv
sv/lru_lfu_eviction_tracker.sv
test/lru_lfu_eviction_checker.sv
test/tb_lru_lfu_eviction_tracker.sv
